// File: hw/rtl/periodic_timer_bank_top_defines.svh
// ---------------------------------------------------------------------------
// Periodic timer bank assertion macros
// Concurrent checks used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_BANK_TOP_DEFINES_SVH
`define PERIODIC_TIMER_BANK_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

`define PTB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("periodic timer bank check failed");

`define PTB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("periodic timer bank check failed");

`else

`define PTB_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define PTB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hw/rtl/ptb_pkg.sv
// ---------------------------------------------------------------------------
// Periodic timer bank package
// Widths, register indexes, time constants and shared types.
// ---------------------------------------------------------------------------
`default_nettype none

package ptb_pkg;

  localparam int CHANNELS  = 4;
  localparam int CH_W      = $clog2(CHANNELS);
  localparam int TIME_W    = 56;
  localparam int PERIOD_W  = 16;
  localparam int PUS_W     = 26;
  localparam int SEC_W     = 16;
  localparam int USEC_W    = 20;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // 1000000 = 15625 << 6; floor(x / 15625) = (x * ceil(2^44 / 15625)) >> 44
  // holds for every x below 2^30
  localparam int US_SHIFT  = 6;
  localparam int QX_W      = 30;
  localparam int RECIP_W   = 31;
  localparam int RECIP_SH  = 44;
  localparam int PROD_W    = QX_W + RECIP_W;
  localparam int QM_W      = SEC_W + USEC_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = CFG_IDX_W'(CHANNELS);
  localparam logic [PERIOD_W-1:0]  PERIOD_RESET = PERIOD_W'(1000);

  localparam logic              CMD_TICK = 1'b0;
  localparam logic              CMD_ARM  = 1'b1;

  localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
  localparam logic [TIME_W-1:0] US_PER_S  = TIME_W'(64'd1000000);
  localparam logic [TIME_W-1:0] SAT_US    = TIME_W'(64'd65536000000);
  localparam logic [USEC_W-1:0] USEC_MAX  = USEC_W'(64'd999999);
  localparam logic [SEC_W-1:0]  SEC_MAX   = {SEC_W{1'b1}};
  localparam logic [USEC_W-1:0] USEC_PER_S = USEC_W'(64'd1000000);
  localparam logic [RECIP_W-1:0] RECIP_M  = RECIP_W'(64'd1125899907);

  typedef struct packed {
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    logic              sub;
  } alu_req_t;

  // x * 1000 = x * 1024 - x * 16 - x * 8
  function automatic logic [PUS_W-1:0] ms_to_us(input logic [PERIOD_W-1:0] ms);
    logic [PUS_W-1:0] x;
    x = PUS_W'(ms);
    return (x << 10) - (x << 4) - (x << 3);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ptb_if.sv
// ---------------------------------------------------------------------------
// Periodic timer bank channels
// Valid/ready interfaces for command words and result words.
// ---------------------------------------------------------------------------
`default_nettype none

interface ptb_item_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [1:0]                   channel;
  logic [ptb_pkg::TIME_W-1:0]   now_us;

  modport source (output valid, command, channel, now_us, input ready);
  modport sink   (input valid, command, channel, now_us, output ready);
endinterface

interface ptb_result_if;
  logic                         valid;
  logic                         ready;
  logic [ptb_pkg::CHANNELS-1:0] fire_mask;
  logic                         have_timers;
  logic [ptb_pkg::SEC_W-1:0]    wait_sec;
  logic [ptb_pkg::USEC_W-1:0]   wait_usec;

  modport source (output valid, fire_mask, have_timers, wait_sec, wait_usec, input ready);
  modport sink   (input valid, fire_mask, have_timers, wait_sec, wait_usec, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/periodic_timer_bank_top.sv
// ---------------------------------------------------------------------------
// Periodic timer bank
// Four periodic timers with microsecond deadlines and a next-wait report.
// ---------------------------------------------------------------------------
// item: command (tick or arm), channel, now_us; one word is taken while idle
//   and ready stays low until its result sits in the output register.
// result: fire_mask, have_timers, wait_sec, wait_usec; one word per item,
//   held in the output register until taken.
// Config: cfg_we, cfg_index, cfg_data; indexes 0..3 set the periods in ms,
//   index 4 the enable mask. Write only while idle.
// Accept to result valid runs on one shared 57-bit adder, with a reciprocal
//   multiply for the seconds split: arm is period, add, min scan, diff, range,
//   split and finish; tick is a compare per channel with advance and clamp
//   for each firing one, then the same min scan to finish. A saturated wait,
//   a past deadline or no enabled channel skips the split. Items go one at a
//   time: the next is taken only once the last result sits in the output
//   register. A stalled receiver holds the next item finished in the block, ready low.
// Reset: periods return to 1000 ms, enable mask and deadlines to zero, the
//   output register empties.
// ---------------------------------------------------------------------------
`default_nettype none
`include "periodic_timer_bank_top_defines.svh"

module periodic_timer_bank_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [ptb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ptb_pkg::CFG_DAT_W-1:0]     cfg_data,
  ptb_item_if.sink                               item,
  ptb_result_if.source                           result
);

  typedef enum logic [3:0] {
    IDLE,
    ARM_P,
    ARM_ADD,
    T_CMP,
    T_ADD,
    T_CLAMP,
    MIN,
    DIFF,
    SAT,
    DIV,
    MOD_SUB,
    FINISH
  } state_t;

  state_t                                state;
  logic [ptb_pkg::CH_W-1:0]              idx;
  logic                                  cmd_q;
  logic [1:0]                            ch_q;
  logic [ptb_pkg::TIME_W-1:0]            now_q;
  logic [ptb_pkg::PUS_W-1:0]             p_us;
  logic [ptb_pkg::TIME_W-1:0]            tmp;
  logic [ptb_pkg::TIME_W-1:0]            earliest;
  logic                                  any;
  logic [ptb_pkg::CHANNELS-1:0]          fired;
  logic [ptb_pkg::TIME_W-1:0]            rem;
  logic [ptb_pkg::SEC_W-1:0]             quo;
  logic [ptb_pkg::TIME_W-1:0]            deadline [ptb_pkg::CHANNELS];
  logic [ptb_pkg::PERIOD_W-1:0]          period_ms [ptb_pkg::CHANNELS];
  logic [ptb_pkg::CHANNELS-1:0]          enabled;

  logic                                  out_valid;
  logic [ptb_pkg::CHANNELS-1:0]          out_fire;
  logic                                  out_have;
  logic [ptb_pkg::SEC_W-1:0]             out_sec;
  logic [ptb_pkg::USEC_W-1:0]            out_usec;

  ptb_pkg::alu_req_t                     alu_req;
  logic [ptb_pkg::TIME_W:0]              alu_res;
  logic                                  carry;
  logic [ptb_pkg::TIME_W-1:0]            alu_val;
  logic                                  last;
  logic [ptb_pkg::PROD_W-1:0]            prod;
  logic [ptb_pkg::QM_W-1:0]              qmul;

  ptb_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign carry   = alu_res[ptb_pkg::TIME_W];
  assign alu_val = alu_res[ptb_pkg::TIME_W-1:0];
  assign last    = (idx == ptb_pkg::CH_W'(ptb_pkg::CHANNELS - 1));

  assign prod = ptb_pkg::PROD_W'(rem[ptb_pkg::QX_W+ptb_pkg::US_SHIFT-1:ptb_pkg::US_SHIFT])
                * ptb_pkg::PROD_W'(ptb_pkg::RECIP_M);
  assign qmul = ptb_pkg::QM_W'(quo) * ptb_pkg::QM_W'(ptb_pkg::USEC_PER_S);

  assign item.ready         = (state == IDLE);
  assign result.valid       = out_valid;
  assign result.fire_mask   = out_fire;
  assign result.have_timers = out_have;
  assign result.wait_sec    = out_sec;
  assign result.wait_usec   = out_usec;

  always_comb begin
    alu_req.a   = now_q;
    alu_req.b   = deadline[idx];
    alu_req.sub = 1'b1;
    case (state)
      ARM_ADD: begin
        alu_req.a   = now_q;
        alu_req.b   = ptb_pkg::TIME_W'(p_us);
        alu_req.sub = 1'b0;
      end
      T_ADD: begin
        alu_req.a   = deadline[idx];
        alu_req.b   = ptb_pkg::TIME_W'(p_us);
        alu_req.sub = 1'b0;
      end
      T_CLAMP: begin
        alu_req.a = tmp;
        alu_req.b = now_q;
      end
      MIN: begin
        alu_req.a = deadline[idx];
        alu_req.b = earliest;
      end
      DIFF: begin
        alu_req.a = earliest;
        alu_req.b = now_q;
      end
      SAT: begin
        alu_req.a = rem;
        alu_req.b = ptb_pkg::SAT_US;
      end
      MOD_SUB: begin
        alu_req.a = rem;
        alu_req.b = ptb_pkg::TIME_W'(qmul);
      end
      default: begin
        alu_req.a = now_q;
        alu_req.b = deadline[idx];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      enabled   <= '0;
      for (int i = 0; i < ptb_pkg::CHANNELS; i++) begin
        period_ms[i] <= ptb_pkg::PERIOD_RESET;
        deadline[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index < ptb_pkg::CFG_ENABLED) begin
          period_ms[cfg_index[ptb_pkg::CH_W-1:0]] <= cfg_data;
        end else if (cfg_index == ptb_pkg::CFG_ENABLED) begin
          enabled <= cfg_data[ptb_pkg::CHANNELS-1:0];
        end
      end

      if (result.valid && result.ready && (state != FINISH)) begin
        out_valid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (item.valid) begin
            cmd_q <= item.command;
            ch_q  <= item.channel;
            now_q <= item.now_us;
            fired <= '0;
            idx   <= '0;
            state <= (item.command == ptb_pkg::CMD_ARM) ? ARM_P : T_CMP;
          end
        end
        ARM_P: begin
          p_us  <= ptb_pkg::ms_to_us(period_ms[ch_q[ptb_pkg::CH_W-1:0]]);
          state <= ARM_ADD;
        end
        ARM_ADD: begin
          deadline[ch_q[ptb_pkg::CH_W-1:0]] <= carry ? ptb_pkg::TIME_MAX : alu_val;
          idx   <= '0;
          any   <= 1'b0;
          state <= MIN;
        end
        T_CMP: begin
          if (enabled[idx] && !carry) begin
            fired[idx] <= 1'b1;
            p_us       <= ptb_pkg::ms_to_us(period_ms[idx]);
            state      <= T_ADD;
          end else if (last) begin
            idx   <= '0;
            any   <= 1'b0;
            state <= MIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        T_ADD: begin
          tmp   <= carry ? ptb_pkg::TIME_MAX : alu_val;
          state <= T_CLAMP;
        end
        T_CLAMP: begin
          deadline[idx] <= carry ? now_q : tmp;
          if (last) begin
            idx   <= '0;
            any   <= 1'b0;
            state <= MIN;
          end else begin
            idx   <= idx + 1'b1;
            state <= T_CMP;
          end
        end
        MIN: begin
          if (enabled[idx]) begin
            any <= 1'b1;
            if (!any || carry) begin
              earliest <= deadline[idx];
            end
          end
          if (last) begin
            state <= DIFF;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        DIFF: begin
          quo <= '0;
          if (!any || carry) begin
            rem   <= '0;
            state <= FINISH;
          end else begin
            rem   <= alu_val;
            state <= SAT;
          end
        end
        SAT: begin
          if (!carry) begin
            quo   <= ptb_pkg::SEC_MAX;
            rem   <= ptb_pkg::TIME_W'(ptb_pkg::USEC_MAX);
            state <= FINISH;
          end else begin
            state <= DIV;
          end
        end
        DIV: begin
          quo   <= prod[ptb_pkg::RECIP_SH+ptb_pkg::SEC_W-1:ptb_pkg::RECIP_SH];
          state <= MOD_SUB;
        end
        MOD_SUB: begin
          rem   <= alu_val;
          state <= FINISH;
        end
        FINISH: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_fire  <= (cmd_q == ptb_pkg::CMD_TICK) ? fired : '0;
            out_have  <= any;
            out_sec   <= quo;
            out_usec  <= rem[ptb_pkg::USEC_W-1:0];
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `PTB_ASSERT_IMPLY(a_idle_wait_zero, clk, rst, (result.valid && !result.have_timers),
                    ((result.wait_sec == '0) && (result.wait_usec == '0)))
  `PTB_ASSERT_IMPLY(a_usec_range, clk, rst, result.valid, (result.wait_usec <= ptb_pkg::USEC_MAX))
  `PTB_ASSERT_NEXT(a_busy_after_take, clk, rst, (item.valid && item.ready), !item.ready)

endmodule

`default_nettype wire

// File: hw/rtl/ptb_alu.sv
// ---------------------------------------------------------------------------
// Periodic timer bank shared adder
// One wide add or subtract; the top bit is carry on add, borrow on subtract.
// ---------------------------------------------------------------------------
`default_nettype none

module ptb_alu (
  input  ptb_pkg::alu_req_t           req,
  output logic [ptb_pkg::TIME_W:0]    res
);

  logic [ptb_pkg::TIME_W:0] a_ext;
  logic [ptb_pkg::TIME_W:0] b_ext;

  assign a_ext = {1'b0, req.a};
  assign b_ext = {1'b0, req.b};

  always_comb begin
    if (req.sub) begin
      res = a_ext - b_ext;
    end else begin
      res = a_ext + b_ext;
    end
  end

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ---------------------------------------------------------------------------
// Periodic timer bank testbench
// Drives arm and tick words through the item channel with random gaps, takes
// result words with random stalls and one long hold-off, and compares every
// result field with a cycle-free model of the deadline bank. Periods and the
// enable mask are reprogrammed between phases while the bank is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import ptb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int PHASES = 13;
  localparam int WORDS_PER_PHASE = 42;
  localparam int MAX_GAP = 18;
  localparam int LONG_HOLD = 400;
  localparam int MAX_PRINTS = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD0 = '0;

  typedef struct packed {
    logic [CHANNELS-1:0] fire_mask;
    logic                have_timers;
    logic [SEC_W-1:0]    wait_sec;
    logic [USEC_W-1:0]   wait_usec;
  } timer_result_t;

  class timer_scoreboard;
    logic [PERIOD_W-1:0] period_ms [CHANNELS];
    logic [CHANNELS-1:0] enabled;
    logic [TIME_W-1:0]   deadline [CHANNELS];
    timer_result_t       pending_results [$];
    int unsigned         failures;

    function new();
      for (int i = 0; i < CHANNELS; i++) begin
        period_ms[i] = PERIOD_RESET;
        deadline[i] = '0;
      end
      enabled = '0;
      failures = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      if (idx < CFG_ENABLED) begin
        period_ms[idx - CFG_PERIOD0] = data[PERIOD_W-1:0];
      end else if (idx == CFG_ENABLED) begin
        enabled = data[CHANNELS-1:0];
      end
    endfunction

    function logic [TIME_W-1:0] period_us(int ch);
      return TIME_W'(period_ms[ch]) * TIME_W'(1000);
    endfunction

    function logic [TIME_W-1:0] add_sat(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    function void note_word(logic cmd, logic [1:0] ch, logic [TIME_W-1:0] now);
      timer_result_t     r;
      logic [TIME_W-1:0] earliest;
      logic [TIME_W-1:0] gap_us;
      logic [TIME_W-1:0] secs;
      logic              found;
      r = '0;
      earliest = '0;
      found = 1'b0;
      if (cmd == CMD_ARM) begin
        if (ch < CHANNELS) deadline[ch] = add_sat(now, period_us(ch));
      end else begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (enabled[i] && deadline[i] <= now) begin
            r.fire_mask[i] = 1'b1;
            deadline[i] = add_sat(deadline[i], period_us(i));
            if (deadline[i] < now) deadline[i] = now;
          end
        end
      end
      for (int i = 0; i < CHANNELS; i++) begin
        if (enabled[i]) begin
          if (!found || deadline[i] < earliest) earliest = deadline[i];
          found = 1'b1;
        end
      end
      r.have_timers = found;
      if (found && earliest > now) begin
        gap_us = earliest - now;
        secs = gap_us / US_PER_S;
        if (secs > TIME_W'(SEC_MAX)) begin
          r.wait_sec = SEC_MAX;
          r.wait_usec = USEC_MAX;
        end else begin
          r.wait_sec = secs[SEC_W-1:0];
          r.wait_usec = USEC_W'(gap_us % US_PER_S);
        end
      end
      pending_results = {pending_results, r};
    endfunction

    task report(string what);
      if (failures < MAX_PRINTS) $display("MISMATCH at %0t: %s", $realtime, what);
      failures++;
    endtask

    task check_word(timer_result_t got);
      timer_result_t want;
      if (pending_results.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (got.fire_mask !== want.fire_mask)
          report($sformatf("fire_mask got %h want %h", got.fire_mask, want.fire_mask));
        if (got.have_timers !== want.have_timers)
          report($sformatf("have_timers got %b want %b", got.have_timers, want.have_timers));
        if (got.wait_sec !== want.wait_sec)
          report($sformatf("wait_sec got %0d want %0d", got.wait_sec, want.wait_sec));
        if (got.wait_usec !== want.wait_usec)
          report($sformatf("wait_usec got %0d want %0d", got.wait_usec, want.wait_usec));
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  int unsigned          cycle_count = 0;
  int                   hold_cycles = 0;
  bit                   idle_src = 1'b0;
  bit                   idle_snk = 1'b0;
  timer_scoreboard      sb = new();

  ptb_item_if   item_bus ();
  ptb_result_if result_bus ();

  periodic_timer_bank_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_bus),
    .result    (result_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  task automatic send_word(input logic cmd, input logic [1:0] ch,
                           input logic [TIME_W-1:0] now);
    int gap;
    gap = idle_src ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.command <= cmd;
    item_bus.channel <= ch;
    item_bus.now_us <= now;
    do @(posedge clk); while (!item_bus.ready);
    sb.note_word(cmd, ch, now);
  endtask

  task automatic settle();
    item_bus.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic program_bank(input logic [PERIOD_W-1:0] periods [CHANNELS],
                              input logic [CHANNELS-1:0] mask);
    logic [CFG_DAT_W-1:0] data;
    settle();
    for (int ch = 0; ch < CHANNELS; ch++) write_reg(CFG_PERIOD0 + CFG_IDX_W'(ch), periods[ch]);
    // unmapped indexes must leave the bank alone
    for (int k = CHANNELS + 1; k < 2 ** CFG_IDX_W; k++)
      write_reg(CFG_IDX_W'(k), CFG_DAT_W'($urandom));
    data = CFG_DAT_W'($urandom);
    data[CHANNELS-1:0] = mask;
    write_reg(CFG_ENABLED, data);
    cfg_we <= 1'b0;
  endtask

  initial begin
    timer_result_t got;
    int            stall;
    result_bus.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = idle_snk ? $urandom_range(0, MAX_GAP) : 0;
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        result_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!result_bus.valid);
      got.fire_mask = result_bus.fire_mask;
      got.have_timers = result_bus.have_timers;
      got.wait_sec = result_bus.wait_sec;
      got.wait_usec = result_bus.wait_usec;
      sb.check_word(got);
    end
  end

  initial begin
    logic [PERIOD_W-1:0] periods [CHANNELS];
    logic [TIME_W-1:0]   base;
    logic [TIME_W-1:0]   step;
    int                  sel;
    int                  first;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    item_bus.valid <= 1'b0;
    item_bus.command <= CMD_TICK;
    item_bus.channel <= '0;
    item_bus.now_us <= '0;
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // nothing enabled; arm a disabled channel
    send_word(CMD_TICK, 2'd0, '0);
    send_word(CMD_ARM, 2'd2, TIME_W'(7));

    periods = '{PERIOD_W'(0), SEC_MAX, PERIOD_W'(1), PERIOD_RESET};
    program_bank(periods, '1);
    send_word(CMD_TICK, 2'd3, '0);
    for (int ch = 0; ch < CHANNELS; ch++) send_word(CMD_ARM, 2'(ch), '0);
    send_word(CMD_TICK, 2'd1, TIME_W'(1000));
    send_word(CMD_TICK, 2'd2, TIME_W'(2500));
    send_word(CMD_ARM, 2'd3, TIME_MAX - TIME_W'(10));
    send_word(CMD_TICK, 2'd0, TIME_MAX);
    send_word(CMD_TICK, 2'd3, TIME_MAX);

    // one channel, longest period: waits below and beyond the 65535 s ceiling
    periods = '{SEC_MAX, SEC_MAX, SEC_MAX, SEC_MAX};
    program_bank(periods, 4'b0010);
    send_word(CMD_ARM, 2'd1, TIME_W'(5));
    send_word(CMD_TICK, 2'd0, TIME_W'(4));
    send_word(CMD_TICK, 2'd0, '0);
    send_word(CMD_ARM, 2'd1, TIME_W'(64'd1000000000000));
    send_word(CMD_TICK, 2'd2, '0);
    send_word(CMD_ARM, 2'd0, TIME_W'(3));

    for (int ch = 0; ch < CHANNELS; ch++) periods[ch] = PERIOD_W'($urandom);
    program_bank(periods, '0);
    send_word(CMD_TICK, 2'd1, rand_time());
    send_word(CMD_ARM, 2'd3, rand_time());

    for (int phase = 0; phase < PHASES; phase++) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        sel = $urandom_range(0, 9);
        case (sel)
          0: periods[ch] = '0;
          1: periods[ch] = SEC_MAX;
          2: periods[ch] = PERIOD_W'($urandom);
          default: periods[ch] = PERIOD_W'($urandom_range(1, 40));
        endcase
      end
      program_bank(periods, CHANNELS'($urandom_range(0, 15)));
      idle_src = $urandom_range(0, 3) != 0;
      idle_snk = $urandom_range(0, 3) != 0;
      if (phase == 3) begin
        idle_src = 1'b0;
        hold_cycles = LONG_HOLD;
      end

      sel = $urandom_range(0, 3);
      if (sel == 0) base = TIME_MAX - TIME_W'($urandom_range(0, 200000));
      else if (sel == 1) base = rand_time();
      else base = TIME_W'({$urandom_range(0, 255), $urandom});

      first = $urandom_range(0, CHANNELS - 1);
      for (int k = 0; k < CHANNELS; k++) send_word(CMD_ARM, 2'((first + k) % CHANNELS), base);

      for (int n = CHANNELS; n < WORDS_PER_PHASE; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
          send_word(1'($urandom), 2'($urandom), rand_time());
        end else if (sel < 20) begin
          send_word(CMD_ARM, 2'($urandom), base);
        end else begin
          step = TIME_W'($urandom_range(0, 60000));
          base = (base > TIME_MAX - step) ? TIME_MAX : base + step;
          send_word(CMD_TICK, 2'($urandom), base);
        end
      end
    end

    settle();
    repeat (40) @(posedge clk);
    if (sb.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
